@@ design/aadd_pkg.sv @@
// Shared types and constants of the AIGER AND-section delta decoder.
package aadd_pkg;

	localparam int CFG_W      = 31;
	localparam int DATA_W     = 8;
	localparam int OUT_W      = 32;
	localparam int STATUS_W   = 2;
	localparam int LHS_W      = 33;  // running literal, 2*(I+L+1) needs 33 bits
	localparam int ACC_W      = 35;  // five 7-bit groups
	localparam int POS_W      = 3;
	localparam int GRP_BITS   = 7;
	localparam int MAX_GROUPS = 5;
	localparam int ADDR_W     = 4;
	localparam int APB_W      = 32;
	localparam int REG_IDX_W  = 2;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
	localparam logic [STATUS_W-1:0] ST_INDEX     = 2'd3;

	localparam logic [REG_IDX_W-1:0] REG_MAX_IDX = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_INPUTS  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_LATCHES = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_GATES   = 2'd3;

	typedef struct packed {
		logic [CFG_W-1:0] max_idx;
		logic [CFG_W-1:0] gate_count;
		logic [LHS_W-1:0] base_lhs;
	} cfg_t;

	typedef struct packed {
		logic [OUT_W-1:0]    lhs;
		logic [OUT_W-1:0]    rhs_first;
		logic [OUT_W-1:0]    rhs_second;
		logic [STATUS_W-1:0] status;
		logic                last;
	} gate_t;

endpackage

@@ design/aadd_if.sv @@
// Stream interfaces: raw bytes in, decoded gates out.
interface aadd_byte_if;
	logic                       valid;
	logic                       ready;
	logic [aadd_pkg::DATA_W-1:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface aadd_gate_if;
	logic                         valid;
	logic                         ready;
	logic [aadd_pkg::OUT_W-1:0]    gate_lhs;
	logic [aadd_pkg::OUT_W-1:0]    gate_rhs_first;
	logic [aadd_pkg::OUT_W-1:0]    gate_rhs_second;
	logic [aadd_pkg::STATUS_W-1:0] status;
	logic                         last;

	modport source (output valid, output gate_lhs, output gate_rhs_first,
		output gate_rhs_second, output status, output last, input ready);
	modport sink (input valid, input gate_lhs, input gate_rhs_first,
		input gate_rhs_second, input status, input last, output ready);
endinterface

@@ design/aadd_cfg_regs.sv @@
// APB register file: header counts and the precomputed first literal.
module aadd_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [aadd_pkg::ADDR_W-1:0] paddr,
	input  logic [aadd_pkg::APB_W-1:0]  pwdata,
	output logic [aadd_pkg::APB_W-1:0]  prdata,
	output logic                        pready,
	output aadd_pkg::cfg_t              cfg
);
	import aadd_pkg::*;

	logic [CFG_W-1:0]     max_idx_q, inputs_q, latches_q, gates_q;
	logic [LHS_W-1:0]     base_q;
	logic                 wr;
	logic [REG_IDX_W-1:0] idx;
	logic [CFG_W-1:0]     inputs_nx, latches_nx;
	logic [OUT_W-1:0]     node_sum;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;
	assign idx    = paddr[ADDR_W-1:2];

	// I+L+1 fits 32 bits; the first literal is twice that
	always_comb begin
		inputs_nx  = (wr && idx == REG_INPUTS) ? pwdata[CFG_W-1:0] : inputs_q;
		latches_nx = (wr && idx == REG_LATCHES) ? pwdata[CFG_W-1:0] : latches_q;
		node_sum   = OUT_W'(inputs_nx) + OUT_W'(latches_nx) + OUT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_idx_q <= '0;
			inputs_q  <= '0;
			latches_q <= '0;
			gates_q   <= '0;
			base_q    <= LHS_W'(2);
		end else if (wr) begin
			unique case (idx)
				REG_MAX_IDX: max_idx_q <= pwdata[CFG_W-1:0];
				REG_INPUTS: begin
					inputs_q <= pwdata[CFG_W-1:0];
					base_q   <= {node_sum, 1'b0};
				end
				REG_LATCHES: begin
					latches_q <= pwdata[CFG_W-1:0];
					base_q    <= {node_sum, 1'b0};
				end
				REG_GATES: gates_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_MAX_IDX: prdata = APB_W'(max_idx_q);
			REG_INPUTS:  prdata = APB_W'(inputs_q);
			REG_LATCHES: prdata = APB_W'(latches_q);
			REG_GATES:   prdata = APB_W'(gates_q);
			default:     prdata = '0;
		endcase
	end

	assign cfg.max_idx    = max_idx_q;
	assign cfg.gate_count = gates_q;
	assign cfg.base_lhs   = base_q;

endmodule

@@ design/aadd_decode.sv @@
// Byte register, LEB128 delta decoding with checks, and gate result register.
module aadd_decode #(
	parameter int LITERAL_BITS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  aadd_pkg::cfg_t cfg,
	aadd_byte_if.sink      byte_in,
	aadd_gate_if.source    gate_out
);
	import aadd_pkg::*;

	// input stage
	logic              vld_s1;
	logic [DATA_W-1:0] byte_s1;

	// decoder state
	logic [LHS_W-1:0]        lhs_q, r0_q;
	logic [LITERAL_BITS-1:0] acc_q;
	logic [POS_W-1:0]        pos_q;
	logic                    phase_q, uf0_q, stop_q;
	logic [CFG_W-1:0]        done_q;

	// result stage
	logic  out_vld_q;
	gate_t res_q;

	logic adv, live, act;
	logic [GRP_BITS-1:0]     payload;
	logic [ACC_W-1:0]        grp, acc_sum;
	logic                    ovf, first;
	logic [LHS_W-1:0]        lhs_cur, val_ext, r0_new, r1;
	logic                    uf1, idx_bad;
	logic [CFG_W-1:0]        done_inc;

	logic [LHS_W-1:0]        lhs_d, r0_d;
	logic [LITERAL_BITS-1:0] acc_d;
	logic [POS_W-1:0]        pos_d;
	logic                    phase_d, uf0_d, stop_d, emit;
	logic [CFG_W-1:0]        done_d;
	gate_t                   res_d;

	assign adv           = !out_vld_q || gate_out.ready;
	assign byte_in.ready = !vld_s1 || adv;
	assign live          = !stop_q && (done_q < cfg.gate_count);
	assign act           = vld_s1 && adv && live;

	assign payload = byte_s1[GRP_BITS-1:0];
	assign first   = (done_q == '0) && (pos_q == '0) && !phase_q;
	assign lhs_cur = first ? cfg.base_lhs : lhs_q;

	// earlier groups sit below the new one, so the sum is an OR
	always_comb begin
		unique case (pos_q)
			3'd0:    grp = ACC_W'(payload);
			3'd1:    grp = ACC_W'(payload) << GRP_BITS;
			3'd2:    grp = ACC_W'(payload) << (2 * GRP_BITS);
			3'd3:    grp = ACC_W'(payload) << (3 * GRP_BITS);
			3'd4:    grp = ACC_W'(payload) << (4 * GRP_BITS);
			default: grp = '0;
		endcase
	end

	assign acc_sum = ACC_W'(acc_q) | grp;
	assign ovf     = (pos_q >= POS_W'(MAX_GROUPS) && payload != '0)
		|| (acc_sum[ACC_W-1:LITERAL_BITS] != '0);
	assign val_ext = LHS_W'(acc_sum[LITERAL_BITS-1:0]);

	assign r0_new   = lhs_cur - val_ext;
	assign r1       = r0_q - val_ext;
	assign uf1      = uf0_q || (val_ext > r0_q);
	assign idx_bad  = (lhs_q[LHS_W-1:1] > (LHS_W-1)'(cfg.max_idx))
		|| (lhs_q[LHS_W-1:LITERAL_BITS] != '0);
	assign done_inc = done_q + CFG_W'(1);

	always_comb begin
		lhs_d   = lhs_q;
		r0_d    = r0_q;
		acc_d   = acc_q;
		pos_d   = pos_q;
		phase_d = phase_q;
		uf0_d   = uf0_q;
		stop_d  = stop_q;
		done_d  = done_q;
		emit    = 1'b0;
		res_d   = '{lhs: '0, rhs_first: '0, rhs_second: '0, status: ST_OK, last: 1'b1};
		if (act) begin
			if (first)
				lhs_d = cfg.base_lhs;
			if (ovf) begin
				emit         = 1'b1;
				stop_d       = 1'b1;
				res_d.status = ST_OVERFLOW;
			end else if (byte_s1[DATA_W-1]) begin
				acc_d = acc_sum[LITERAL_BITS-1:0];
				if (pos_q != '1)
					pos_d = pos_q + POS_W'(1);
			end else begin
				acc_d = '0;
				pos_d = '0;
				if (!phase_q) begin
					// first delta done: subtract it now, check the second later
					phase_d = 1'b1;
					r0_d    = r0_new;
					uf0_d   = val_ext > lhs_cur;
				end else begin
					phase_d = 1'b0;
					emit    = 1'b1;
					if (uf1) begin
						stop_d       = 1'b1;
						res_d.status = ST_UNDERFLOW;
					end else if (idx_bad) begin
						stop_d       = 1'b1;
						res_d.status = ST_INDEX;
					end else begin
						done_d           = done_inc;
						lhs_d            = lhs_q + LHS_W'(2);
						res_d.lhs        = lhs_q[OUT_W-1:0];
						res_d.rhs_first  = r0_q[OUT_W-1:0];
						res_d.rhs_second = r1[OUT_W-1:0];
						res_d.last       = done_inc >= cfg.gate_count;
						stop_d           = res_d.last;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
			lhs_q     <= LHS_W'(2);
			r0_q      <= '0;
			acc_q     <= '0;
			pos_q     <= '0;
			phase_q   <= 1'b0;
			uf0_q     <= 1'b0;
			stop_q    <= 1'b0;
			done_q    <= '0;
		end else begin
			if (byte_in.ready)
				vld_s1 <= byte_in.valid;
			if (adv)
				out_vld_q <= emit;
			lhs_q   <= lhs_d;
			r0_q    <= r0_d;
			acc_q   <= acc_d;
			pos_q   <= pos_d;
			phase_q <= phase_d;
			uf0_q   <= uf0_d;
			stop_q  <= stop_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.ready && byte_in.valid)
			byte_s1 <= byte_in.data_byte;
		if (emit)
			res_q <= res_d;
	end

	assign gate_out.valid           = out_vld_q;
	assign gate_out.gate_lhs        = res_q.lhs;
	assign gate_out.gate_rhs_first  = res_q.rhs_first;
	assign gate_out.gate_rhs_second = res_q.rhs_second;
	assign gate_out.status          = res_q.status;
	assign gate_out.last            = res_q.last;

	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stop_q |=> stop_q)
		else $error("stop flag cleared");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && res_q.status != ST_OK |-> res_q.last && res_q.lhs == '0)
		else $error("error result not final or not zeroed");

	a_last_stops: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && res_q.last |-> stop_q)
		else $error("final result without stop");

	a_lhs_even: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && res_q.status == ST_OK |-> !res_q.lhs[0])
		else $error("odd gate literal");

	a_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q == '0 |-> acc_q == '0)
		else $error("accumulator not clear at number start");

endmodule

@@ design/aiger_and_delta_decoder_core.sv @@
// Top level of the binary AIGER AND-section delta decoder.
// Usage: write max_variable_index, input_count, latch_count and gate_count
// over APB (byte addresses 0, 4, 8, 12) while no bytes are in flight, then
// stream the AND-section bytes on byte_in. Each pair of LEB128 numbers
// yields one gate request on gate_out: lhs, rhs_first, rhs_second, status
// and last. Status flags number overflow, delta underflow or an index above
// the maximum; an error result carries zero literals, sets last and stops
// the block. After gate_count gates, or after an error, bytes are taken and
// dropped.
// Throughput: one byte per cycle while gate_out does not stall; the decode is
// one registered pass from a byte register to the result register: a closing
// byte is accepted into the byte register, then its result is registered.
// When gate_out stalls, the result register holds and one more byte waits
// in the byte register; byte_in.ready drops only while both are full.
// Reset clears the valid flags and puts the decoder state in its start state;
// the byte and result data registers are not reset; no clearing pass is needed.
module aiger_and_delta_decoder_core #(
	parameter int LITERAL_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [aadd_pkg::ADDR_W-1:0] paddr,
	input  logic [aadd_pkg::APB_W-1:0]  pwdata,
	output logic [aadd_pkg::APB_W-1:0]  prdata,
	output logic                        pready,
	aadd_byte_if.sink                   byte_in,
	aadd_gate_if.source                 gate_out
);
	import aadd_pkg::*;

	cfg_t cfg;

	aadd_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	aadd_decode #(
		.LITERAL_BITS (LITERAL_BITS)
	) u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.byte_in  (byte_in),
		.gate_out (gate_out)
	);

endmodule

@@ verif/aadd_gate_checker.sv @@
// Gate checker: mirrors the decoder from the observed bytes and register writes, compares gates.
module aadd_gate_checker import aadd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic                pready,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [APB_W-1:0]    pwdata,
	input  logic                byte_valid,
	input  logic                byte_ready,
	input  logic [DATA_W-1:0]   data_byte,
	input  logic                gate_valid,
	input  logic                gate_ready,
	input  logic [OUT_W-1:0]    gate_lhs,
	input  logic [OUT_W-1:0]    gate_rhs_first,
	input  logic [OUT_W-1:0]    gate_rhs_second,
	input  logic [STATUS_W-1:0] status,
	input  logic                last,
	output int                  mismatches,
	output int                  gates_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [ACC_W-1:0] ACC_LIMIT = 35'h0_FFFF_FFFF;
	localparam logic [LHS_W-1:0] LIT_LIMIT = 33'h0_FFFF_FFFF;

	logic [CFG_W-1:0] cfg_max;
	logic [CFG_W-1:0] cfg_inputs;
	logic [CFG_W-1:0] cfg_latches;
	logic [CFG_W-1:0] cfg_gates;

	logic [LHS_W-1:0] lit;
	logic [ACC_W-1:0] acc;
	logic [POS_W-1:0] pos;
	logic             second_half;
	logic [OUT_W-1:0] first_delta;
	logic [CFG_W-1:0] gates_done;
	logic             halted;

	gate_t gates_due[$];
	gate_t due;

	task automatic post_error(input logic [STATUS_W-1:0] code);
		gate_t g;
		g = '0;
		g.status = code;
		g.last = 1'b1;
		halted = 1'b1;
		gates_due.insert(gates_due.size(), g);
	endtask

	task automatic decode_byte(input logic [DATA_W-1:0] b);
		logic [GRP_BITS-1:0] grp;
		logic [ACC_W-1:0]    value;
		logic [32:0]         half_base;
		logic [LHS_W-1:0]    d0;
		logic [LHS_W-1:0]    d1;
		logic [LHS_W-1:0]    r0;
		logic [LHS_W-1:0]    r1;
		gate_t               g;
		grp = b[GRP_BITS-1:0];
		if (halted || gates_done >= cfg_gates)
			return;
		// base literal is taken from I and L only at the start of the first gate
		if (gates_done == '0 && pos == '0 && !second_half) begin
			half_base = {2'b0, cfg_inputs} + {2'b0, cfg_latches} + 33'd1;
			lit = {half_base[31:0], 1'b0};
		end
		if (pos < POS_W'(MAX_GROUPS))
			acc = acc + (ACC_W'(grp) << (GRP_BITS * pos));
		else if (grp != '0) begin
			post_error(ST_OVERFLOW);
			return;
		end
		if (acc > ACC_LIMIT) begin
			post_error(ST_OVERFLOW);
			return;
		end
		if (b[7]) begin
			if (pos < 3'd7)
				pos = pos + 3'd1;
			return;
		end
		value = acc;
		acc = '0;
		pos = '0;
		if (!second_half) begin
			first_delta = value[OUT_W-1:0];
			second_half = 1'b1;
			return;
		end
		second_half = 1'b0;
		d0 = {1'b0, first_delta};
		d1 = {1'b0, value[OUT_W-1:0]};
		if (d0 > lit || d1 > lit - d0) begin
			post_error(ST_UNDERFLOW);
			return;
		end
		r0 = lit - d0;
		r1 = r0 - d1;
		if ((lit >> 1) > {2'b0, cfg_max} || lit > LIT_LIMIT) begin
			post_error(ST_INDEX);
			return;
		end
		g.lhs = lit[OUT_W-1:0];
		g.rhs_first = r0[OUT_W-1:0];
		g.rhs_second = r1[OUT_W-1:0];
		g.status = ST_OK;
		gates_done = gates_done + CFG_W'(1);
		lit = lit + 33'd2;
		g.last = (gates_done >= cfg_gates);
		if (g.last)
			halted = 1'b1;
		gates_due.insert(gates_due.size(), g);
	endtask

	task automatic field_check(input string name, input logic [OUT_W-1:0] want,
		input logic [OUT_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_max = '0;
			cfg_inputs = '0;
			cfg_latches = '0;
			cfg_gates = '0;
			lit = 33'd2;
			acc = '0;
			pos = '0;
			second_half = 1'b0;
			first_delta = '0;
			gates_done = '0;
			halted = 1'b0;
			gates_due.delete();
			gates_pending = 0;
			mismatches = 0;
		end else begin
			// the gate accepted now is always older than one predicted from this byte
			if (gate_valid && gate_ready) begin
				if (gates_due.size() == 0) begin
					$error("gate request with none expected: lhs %0h status %0h",
						gate_lhs, status);
					mismatches++;
				end else begin
					due = gates_due.pop_front();
					field_check("gate_lhs", due.lhs, gate_lhs);
					field_check("gate_rhs_first", due.rhs_first, gate_rhs_first);
					field_check("gate_rhs_second", due.rhs_second, gate_rhs_second);
					field_check("status", OUT_W'(due.status), OUT_W'(status));
					field_check("last", OUT_W'(due.last), OUT_W'(last));
				end
			end
			if (byte_valid && byte_ready)
				decode_byte(data_byte);
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_MAX_IDX: cfg_max = pwdata[CFG_W-1:0];
					REG_INPUTS:  cfg_inputs = pwdata[CFG_W-1:0];
					REG_LATCHES: cfg_latches = pwdata[CFG_W-1:0];
					REG_GATES:   cfg_gates = pwdata[CFG_W-1:0];
					default: ;
				endcase
			end
			gates_pending = gates_due.size();
		end
	end

endmodule

@@ verif/aiger_and_delta_decoder_core_test.sv @@
// Testbench top: drives register writes and AND-section byte streams, gives the verdict.
module aiger_and_delta_decoder_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import aadd_pkg::*;

	localparam int FIRST_GATES = 3;
	localparam int RAND_GATES  = 148;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN       = 6;
	localparam longint unsigned LIT_TOP = 64'hFFFF_FFFF;
	localparam logic [CFG_W-1:0] CFG_TOP = '1;

	// how the stream is brought to its end; only one per run since stop is sticky
	typedef enum int {
		END_COMPLETE,
		END_BIG_NUMBER,
		END_LONG_NUMBER,
		END_DELTA0_UNDER,
		END_DELTA1_UNDER,
		END_INDEX,
		END_LIT_WRAP
	} run_end_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [APB_W-1:0]  pwdata;
	logic [APB_W-1:0]  prdata;
	logic              pready;

	aadd_byte_if byte_bus ();
	aadd_gate_if gate_bus ();

	int              mismatches;
	int              gates_pending;
	int              cycles = 0;
	bit              calm = 1'b0;
	bit              long_hold_req = 1'b0;
	longint unsigned next_lit;
	int              gates_sent;
	run_end_t        run_end;

	aiger_and_delta_decoder_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.byte_in  (byte_bus),
		.gate_out (gate_bus)
	);

	aadd_gate_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.pready          (pready),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.byte_valid      (byte_bus.valid),
		.byte_ready      (byte_bus.ready),
		.data_byte       (byte_bus.data_byte),
		.gate_valid      (gate_bus.valid),
		.gate_ready      (gate_bus.ready),
		.gate_lhs        (gate_bus.gate_lhs),
		.gate_rhs_first  (gate_bus.gate_rhs_first),
		.gate_rhs_second (gate_bus.gate_rhs_second),
		.status          (gate_bus.status),
		.last            (gate_bus.last),
		.mismatches      (mismatches),
		.gates_pending   (gates_pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("aiger_and_delta_decoder_core_test: FAIL");
			$finish;
		end
	end

	// gate receiver: short random stalls, one long hold-off on request
	initial begin
		int hold;
		bit long_done;
		hold = 0;
		long_done = 1'b0;
		gate_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				gate_bus.ready <= 1'b0;
				hold--;
			end else if (long_hold_req && !long_done) begin
				long_done = 1'b1;
				gate_bus.ready <= 1'b0;
				hold = 149;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				gate_bus.ready <= 1'b0;
				hold = $urandom_range(0, 2);
			end else begin
				gate_bus.ready <= 1'b1;
			end
		end
	end

	task automatic push_byte(input logic [DATA_W-1:0] b);
		if (!calm && $urandom_range(0, 4) == 0) begin
			byte_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		byte_bus.valid <= 1'b1;
		byte_bus.data_byte <= b;
		@(posedge clk);
		while (!byte_bus.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {1'b0, v};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	// no bytes offered, every expected gate taken, then the DRAIN margin
	task automatic settle();
		byte_bus.valid <= 1'b0;
		@(negedge clk);
		while (gates_pending != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	// LEB128 with optional zero-payload padding groups
	task automatic send_number(input longint unsigned v, input int pad);
		int n;
		int total;
		logic [GRP_BITS-1:0] grp;
		n = 1;
		while (n < MAX_GROUPS && (v >> (GRP_BITS * n)) != 0)
			n++;
		total = n + pad;
		for (int i = 0; i < total; i++) begin
			grp = (i < MAX_GROUPS) ? GRP_BITS'(v >> (GRP_BITS * i)) : '0;
			push_byte({i < total - 1, grp});
		end
	endtask

	function automatic int pad_count();
		return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
	endfunction

	function automatic longint unsigned pick_delta(input longint unsigned ceiling);
		int w;
		longint unsigned d;
		if (ceiling > LIT_TOP)
			ceiling = LIT_TOP;
		w = $urandom_range(0, 34);
		if (w > 32)
			return ceiling;
		d = longint'($urandom) & ((64'd1 << w) - 64'd1);
		if (d > ceiling)
			d = d % (ceiling + 1);
		return d;
	endfunction

	task automatic send_gate(input longint unsigned d0, input longint unsigned d1,
		input int pad0, input int pad1);
		send_number(d0, pad0);
		send_number(d1, pad1);
		gates_sent++;
		next_lit += 2;
	endtask

	task automatic send_random_gate();
		longint unsigned d0;
		d0 = pick_delta(next_lit);
		send_gate(d0, pick_delta(next_lit - d0), pad_count(), pad_count());
	endtask

	initial begin
		int unsigned k;
		longint unsigned s;
		longint unsigned d0;
		bit tight_max;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		byte_bus.valid = 1'b0;
		byte_bus.data_byte = '0;
		tight_max = 1'b0;
		run_end = run_end_t'($urandom_range(0, 6));
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// no gates configured: bytes are dropped
		push_byte(8'h00);
		push_byte(8'hFF);
		settle();
		apb_write(REG_MAX_IDX, '0);
		apb_write(REG_INPUTS, '0);
		apb_write(REG_LATCHES, '0);
		apb_write(REG_GATES, '0);
		push_byte(8'h81);
		push_byte(8'h7F);
		settle();
		apb_write(REG_MAX_IDX, CFG_TOP);
		apb_write(REG_INPUTS, CFG_TOP);
		apb_write(REG_LATCHES, CFG_TOP);
		push_byte(8'h80);
		push_byte(8'h00);
		settle();

		// base literal; for the wrap ending it reaches 2^32 exactly at the last gate
		if (run_end == END_LIT_WRAP)
			s = (64'd1 << 31) - (FIRST_GATES + RAND_GATES);
		else
			s = $urandom_range(32'h1000_0000, 32'h7FFF_FC00);
		k = $urandom_range(0, s - 1);
		apb_write(REG_INPUTS, CFG_W'(k));
		apb_write(REG_LATCHES, CFG_W'(s - 1 - k));
		apb_write(REG_GATES, CFG_TOP);
		next_lit = 2 * s;
		gates_sent = 0;

		// both operands equal lhs, first operand zero, padded number past saturation
		send_gate(0, 0, 0, 0);
		send_gate(next_lit, 0, 0, 0);
		send_gate(0, next_lit, 8, 0);
		settle();

		for (int i = 0; i < RAND_GATES; i++) begin
			if (i == 50)
				long_hold_req = 1'b1;
			if (i == RAND_GATES * 4 / 5)
				calm = 1'b1;
			if (tight_max) begin
				settle();
				apb_write(REG_MAX_IDX, CFG_TOP);
				tight_max = 1'b0;
			end
			if (i % 32 == 16) begin
				settle();
				case ((i / 32) % 3)
					0: begin
						// index exactly at the maximum still passes
						apb_write(REG_MAX_IDX, CFG_W'(next_lit / 2));
						tight_max = 1'b1;
					end
					1: begin
						// gate count at or below gates done: bytes dropped, stream resumes
						apb_write(REG_GATES, CFG_W'($urandom_range(0, 1) ? gates_sent : 0));
						repeat ($urandom_range(3, 8))
							push_byte(DATA_W'($urandom_range(0, 255)));
						settle();
						apb_write(REG_GATES, CFG_W'($urandom_range(0, 1) ? CFG_TOP :
							$urandom_range(1000, 32'h7FFF_FFFF)));
					end
					default: begin
						// I and L no longer matter once the first gate is out
						apb_write(REG_INPUTS, CFG_W'($urandom_range(0, 32'h7FFF_FFFF)));
						apb_write(REG_LATCHES, CFG_W'($urandom_range(0, 32'h7FFF_FFFF)));
					end
				endcase
			end
			send_random_gate();
		end
		settle();
		if (tight_max)
			apb_write(REG_MAX_IDX, CFG_TOP);

		case (run_end)
			END_COMPLETE: begin
				apb_write(REG_GATES, CFG_W'(gates_sent + 1));
				send_random_gate();
			end
			END_BIG_NUMBER: begin
				if ($urandom_range(0, 1))
					send_number(pick_delta(next_lit), 0);
				repeat (4) push_byte(8'h80 | 8'($urandom_range(0, 127)));
				push_byte({1'($urandom_range(0, 1)), 7'($urandom_range(16, 127))});
			end
			END_LONG_NUMBER: begin
				repeat (4) push_byte(8'h80 | 8'($urandom_range(0, 127)));
				push_byte(8'h80 | 8'($urandom_range(0, 15)));
				repeat ($urandom_range(0, 2)) push_byte(8'h80);
				push_byte({1'($urandom_range(0, 1)), 7'($urandom_range(1, 127))});
			end
			END_DELTA0_UNDER: begin
				send_gate(next_lit + 1 + $urandom_range(0, LIT_TOP - next_lit - 1),
					pick_delta(LIT_TOP), 0, pad_count());
			end
			END_DELTA1_UNDER: begin
				d0 = pick_delta(next_lit);
				send_gate(d0, next_lit - d0 + 1 +
					$urandom_range(0, LIT_TOP - (next_lit - d0) - 1), pad_count(), 0);
			end
			END_INDEX: begin
				apb_write(REG_MAX_IDX, CFG_W'(next_lit / 2 - 1));
				send_random_gate();
			end
			default: send_random_gate();
		endcase
		// stopped for good: these are dropped
		repeat (4) push_byte(DATA_W'($urandom_range(0, 255)));
		settle();

		if (mismatches == 0)
			$display("aiger_and_delta_decoder_core_test: PASS");
		else
			$display("aiger_and_delta_decoder_core_test: FAIL");
		$finish;
	end

endmodule
